@@ sv/spa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared opcodes and single-precision constants for the softened potential
// accumulator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_RECIP = 3'd3;
  localparam logic [2:0] OP_SQRT  = 3'd4;

  localparam logic [31:0] FP_TINY_R2 = 32'h1E3CE508;
  localparam logic [31:0] FP_KC2     = 32'h3EC00000;
  localparam logic [31:0] FP_KC1     = 32'hBFA00000;
  localparam logic [31:0] FP_KC0     = 32'h3FF00000;
  localparam logic [31:0] FP_ONE     = 32'h3F800000;
  localparam logic [31:0] FP_QNAN    = 32'hFFC00000;

  localparam logic [1:0] REG_SOFT_RADIUS_SQ  = 2'd0;
  localparam logic [1:0] REG_SOFT_RADIUS_INV = 2'd1;
  localparam logic [1:0] REG_GRAV_CONST      = 2'd2;

endpackage

@@ sv/spa_fpu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_fpu
// Shared single-precision unit: add, subtract, multiply, reciprocal and
// square root, round to nearest even, one result per start.
// ----------------------------------------------------------------------------
module spa_fpu import spa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ITER  = 2'd1;
  localparam logic [1:0] ST_NORM  = 2'd2;
  localparam logic [1:0] ST_ROUND = 2'd3;

  function automatic logic [5:0] lzc52(input logic [51:0] v);
    logic [5:0] n;
    logic       fnd;
    n = 6'd0;
    fnd = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!fnd) begin
        if (v[i]) fnd = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  logic [1:0]         state;
  logic               is_sqrt;
  logic [4:0]         cnt;
  logic [51:0]        m;
  logic [51:0]        rem;
  logic [51:0]        one;
  logic signed [11:0] x;
  logic               sg;
  logic               stk;
  logic               spc;
  logic [31:0]        spv;
  logic [51:0]        nm;
  logic signed [11:0] ne;

  // decode
  logic               d_spc, d_iter, d_sqrt, d_sg;
  logic [31:0]        d_spv;
  logic signed [11:0] d_x;
  logic [51:0]        d_m, d_rem, d_one;
  logic [4:0]         d_cnt;

  always_comb begin
    logic        sa, sb, sbe, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb, mbig, msml;
    logic [8:0]  xa, xb, xbig, xsml, dsh;
    logic [26:0] big27, sml27, sml_sh;
    logic [27:0] sum28;
    logic [47:0] prod;
    logic [51:0] sm;
    logic signed [11:0] ex;
    sa = a[31]; ea = a[30:23]; fa = a[22:0];
    sb = b[31]; eb = b[30:23]; fb = b[22:0];
    sbe = sb ^ (op == OP_SUB);
    a_nan = (ea == 8'hFF) && (fa != 23'd0);
    b_nan = (eb == 8'hFF) && (fb != 23'd0);
    a_inf = (ea == 8'hFF) && (fa == 23'd0);
    b_inf = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    xa = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
    xb = (eb == 8'd0) ? 9'd1 : {1'b0, eb};

    a_big = (a[30:0] >= b[30:0]);
    mbig = a_big ? ma : mb;
    msml = a_big ? mb : ma;
    xbig = a_big ? xa : xb;
    xsml = a_big ? xb : xa;
    dsh = xbig - xsml;
    big27 = {mbig, 3'b000};
    sml27 = {msml, 3'b000};
    if (dsh >= 9'd27) begin
      sml_sh = 27'd1;
    end else begin
      sml_sh = sml27 >> dsh;
      if ((sml27 & ((27'd1 << dsh) - 27'd1)) != 27'd0) sml_sh[0] = 1'b1;
    end
    if (sa == sbe) sum28 = {1'b0, big27} + {1'b0, sml_sh};
    else sum28 = {1'b0, big27} - {1'b0, sml_sh};

    prod = ma * mb;

    sm = {28'd0, ma};
    ex = $signed({3'b000, xa}) - 12'sd150;
    if (ex[0]) begin
      sm = {sm[50:0], 1'b0};
      ex = ex - 12'sd1;
    end

    d_spc = 1'b0;
    d_spv = 32'd0;
    d_iter = 1'b0;
    d_sqrt = 1'b0;
    d_sg = 1'b0;
    d_x = 12'sd0;
    d_m = 52'd0;
    d_rem = 52'd0;
    d_one = 52'd0;
    d_cnt = 5'd0;

    case (op)
      OP_ADD, OP_SUB: begin
        d_spc = 1'b1;
        if (a_nan) d_spv = a | 32'h00400000;
        else if (b_nan) d_spv = b | 32'h00400000;
        else if (a_inf && b_inf && (sa != sbe)) d_spv = FP_QNAN;
        else if (a_inf) d_spv = {sa, 8'hFF, 23'd0};
        else if (b_inf) d_spv = {sbe, 8'hFF, 23'd0};
        else if (a_zero && b_zero) d_spv = {sa & sbe, 31'd0};
        else if (a_zero) d_spv = {sbe, b[30:0]};
        else if (b_zero) d_spv = a;
        else if (sum28 == 28'd0) d_spv = 32'd0;
        else begin
          d_spc = 1'b0;
          d_sg = a_big ? sa : sbe;
          d_m = {24'd0, sum28};
          d_x = $signed({3'b000, xbig}) - 12'sd153;
        end
      end
      OP_MUL: begin
        d_spc = 1'b1;
        if (a_nan) d_spv = a | 32'h00400000;
        else if (b_nan) d_spv = b | 32'h00400000;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) d_spv = FP_QNAN;
        else if (a_inf || b_inf) d_spv = {sa ^ sb, 8'hFF, 23'd0};
        else if (a_zero || b_zero) d_spv = {sa ^ sb, 31'd0};
        else begin
          d_spc = 1'b0;
          d_sg = sa ^ sb;
          d_m = {4'd0, prod};
          d_x = $signed({3'b000, xa}) + $signed({3'b000, xb}) - 12'sd300;
        end
      end
      OP_RECIP: begin
        d_spc = 1'b1;
        if (b_nan) d_spv = b | 32'h00400000;
        else if (b_zero) d_spv = {sb, 8'hFF, 23'd0};
        else if (b_inf) d_spv = {sb, 31'd0};
        else begin
          d_spc = 1'b0;
          d_iter = 1'b1;
          d_sg = sb;
          d_one = {28'd0, mb};
          d_rem = 52'd1 << 23;
          d_cnt = 5'd26;
          d_x = 12'sd101 - $signed({3'b000, xb});
        end
      end
      OP_SQRT: begin
        if ((ea == 8'hFF) || (ea == 8'd0)) begin
          d_spc = 1'b1;
          d_spv = a;
        end else begin
          d_iter = 1'b1;
          d_sqrt = 1'b1;
          d_rem = sm << 26;
          d_one = 52'd1 << 50;
          d_cnt = 5'd25;
          d_x = (ex >>> 1) - 12'sd13;
        end
      end
      default: begin
        d_spc = 1'b1;
        d_spv = FP_QNAN;
      end
    endcase
  end

  // one quotient or root bit a cycle
  logic        ge;
  logic [51:0] trial, rem_sub, res_n;

  always_comb begin
    trial = is_sqrt ? (m + one) : one;
    ge = (rem >= trial);
    rem_sub = ge ? (rem - trial) : rem;
    if (is_sqrt) res_n = ge ? ((m >> 1) + one) : (m >> 1);
    else res_n = {m[50:0], ge};
  end

  // rounding and packing
  logic [31:0] rnd_res;

  always_comb begin
    logic signed [11:0] sh;
    logic [51:0] shd;
    logic        lost, g, st;
    logic [23:0] kept;
    logic [31:0] base, rnd;
    sh = 12'sd1 - ne;
    shd = 52'd0;
    lost = 1'b0;
    kept = 24'd0;
    g = 1'b0;
    st = 1'b0;
    base = 32'd0;
    if (ne >= 12'sd1) begin
      kept = nm[51:28];
      g = nm[27];
      st = (|nm[26:0]) | stk;
      base = {1'b0, ne[7:0] - 8'd1, 23'd0} + {8'd0, kept};
    end else if (sh >= 12'sd26) begin
      st = 1'b1;
    end else begin
      shd = nm >> sh[4:0];
      lost = ((nm & ((52'd1 << sh[4:0]) - 52'd1)) != 52'd0);
      kept = shd[51:28];
      g = shd[27];
      st = (|shd[26:0]) | lost | stk;
      base = {8'd0, kept};
    end
    rnd = base + {31'd0, g & (st | kept[0])};
    if (spc) rnd_res = spv;
    else if (ne >= 12'sd255) rnd_res = {sg, 8'hFF, 23'd0};
    else rnd_res = {sg, rnd[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == ST_ROUND);
      case (state)
        ST_IDLE: begin
          if (start) begin
            spc <= d_spc;
            spv <= d_spv;
            sg <= d_sg;
            x <= d_x;
            m <= d_m;
            rem <= d_rem;
            one <= d_one;
            cnt <= d_cnt;
            is_sqrt <= d_sqrt;
            stk <= 1'b0;
            if (d_spc) state <= ST_ROUND;
            else if (d_iter) state <= ST_ITER;
            else state <= ST_NORM;
          end
        end
        ST_ITER: begin
          m <= res_n;
          rem <= is_sqrt ? rem_sub : {rem_sub[50:0], 1'b0};
          one <= is_sqrt ? (one >> 2) : one;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            stk <= (rem_sub != 52'd0);
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          nm <= m << lzc52(m);
          ne <= x + 12'sd178 - $signed({6'd0, lzc52(m)});
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          result <= rnd_res;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/softened_potential_accumulator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_potential_accumulator_core
// Direct-sum softened potential: one source per beat, running sum, scaled
// potential out on the final source.
// ----------------------------------------------------------------------------
// A final source adds one operation for the scaled potential, which waits for a
// pending beat to be taken. The block is not ready while it works on a source.
// All operations share the one float unit: 12 per source on the far path and
// 18 on the near path.
// Reset: registers return to 1.0, the running sum to +0, no result pending.
module softened_potential_accumulator_core import spa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [31:0] source_x,
  input  logic [31:0] source_y,
  input  logic [31:0] source_z,
  input  logic [31:0] source_mass,
  input  logic        final_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] potential
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  localparam logic [4:0] STEP_DX      = 5'd0;
  localparam logic [4:0] STEP_DY      = 5'd1;
  localparam logic [4:0] STEP_DZ      = 5'd2;
  localparam logic [4:0] STEP_SX      = 5'd3;
  localparam logic [4:0] STEP_SY      = 5'd4;
  localparam logic [4:0] STEP_SZ      = 5'd5;
  localparam logic [4:0] STEP_R2A     = 5'd6;
  localparam logic [4:0] STEP_R2B     = 5'd7;
  localparam logic [4:0] STEP_SQRT    = 5'd8;
  localparam logic [4:0] STEP_RECIP   = 5'd9;
  localparam logic [4:0] STEP_Q       = 5'd10;
  localparam logic [4:0] STEP_Q2      = 5'd11;
  localparam logic [4:0] STEP_P0      = 5'd12;
  localparam logic [4:0] STEP_P1      = 5'd13;
  localparam logic [4:0] STEP_P2      = 5'd14;
  localparam logic [4:0] STEP_P3      = 5'd15;
  localparam logic [4:0] STEP_FAC     = 5'd16;
  localparam logic [4:0] STEP_CONTRIB = 5'd17;
  localparam logic [4:0] STEP_SUM     = 5'd18;
  localparam logic [4:0] STEP_OUT     = 5'd19;

  function automatic logic f_gt(input logic [31:0] u, input logic [31:0] v);
    logic nan_u, nan_v;
    nan_u = (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
    nan_v = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    if (nan_u || nan_v) return 1'b0;
    if ((u[30:0] == 31'd0) && (v[30:0] == 31'd0)) return 1'b0;
    if (u[31] != v[31]) return v[31];
    if (u[31]) return (u[30:0] < v[30:0]);
    return (u[30:0] > v[30:0]);
  endfunction

  logic [31:0] soft_radius_sq, soft_radius_inv, grav_const;
  logic [31:0] tx, ty, tz, sx, sy, sz, mass;
  logic        fin;
  logic [31:0] dx, dy, dz, r2, rr, pp, fac, sum;
  logic [1:0]  state;
  logic [4:0]  step;
  logic [1:0]  state_next;
  logic [4:0]  step_next;

  logic        fpu_start, fpu_done;
  logic [2:0]  fpu_op;
  logic [31:0] fpu_a, fpu_b, fpu_res;

  spa_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_res)
  );

  always_comb begin
    fpu_op = OP_ADD;
    fpu_a = 32'd0;
    fpu_b = 32'd0;
    case (step)
      STEP_DX:      begin fpu_op = OP_SUB;   fpu_a = tx;    fpu_b = sx;    end
      STEP_DY:      begin fpu_op = OP_SUB;   fpu_a = ty;    fpu_b = sy;    end
      STEP_DZ:      begin fpu_op = OP_SUB;   fpu_a = tz;    fpu_b = sz;    end
      STEP_SX:      begin fpu_op = OP_MUL;   fpu_a = dx;    fpu_b = dx;    end
      STEP_SY:      begin fpu_op = OP_MUL;   fpu_a = dy;    fpu_b = dy;    end
      STEP_SZ:      begin fpu_op = OP_MUL;   fpu_a = dz;    fpu_b = dz;    end
      STEP_R2A:     begin fpu_op = OP_ADD;   fpu_a = dx;    fpu_b = dy;    end
      STEP_R2B:     begin fpu_op = OP_ADD;   fpu_a = r2;    fpu_b = dz;    end
      STEP_SQRT:    begin fpu_op = OP_SQRT;  fpu_a = r2;    fpu_b = r2;    end
      STEP_RECIP:   begin fpu_op = OP_RECIP; fpu_a = FP_ONE; fpu_b = rr;   end
      STEP_Q:       begin fpu_op = OP_MUL;   fpu_a = rr;    fpu_b = soft_radius_inv; end
      STEP_Q2:      begin fpu_op = OP_MUL;   fpu_a = pp;    fpu_b = pp;    end
      STEP_P0:      begin fpu_op = OP_MUL;   fpu_a = FP_KC2; fpu_b = dx;   end
      STEP_P1:      begin fpu_op = OP_ADD;   fpu_a = pp;    fpu_b = FP_KC1; end
      STEP_P2:      begin fpu_op = OP_MUL;   fpu_a = pp;    fpu_b = dx;    end
      STEP_P3:      begin fpu_op = OP_ADD;   fpu_a = pp;    fpu_b = FP_KC0; end
      STEP_FAC:     begin fpu_op = OP_MUL;   fpu_a = pp;    fpu_b = soft_radius_inv; end
      STEP_CONTRIB: begin fpu_op = OP_MUL;   fpu_a = mass;  fpu_b = fac;   end
      STEP_SUM:     begin fpu_op = OP_SUB;   fpu_a = sum;   fpu_b = fac;   end
      STEP_OUT:     begin fpu_op = OP_MUL;   fpu_a = sum;   fpu_b = grav_const; end
      default:      begin fpu_op = OP_ADD;   fpu_a = 32'd0; fpu_b = 32'd0; end
    endcase
  end

  // advance after each finished operation
  always_comb begin
    step_next = step + 5'd1;
    state_next = S_ISSUE;
    case (step)
      STEP_SQRT:  step_next = f_gt(r2, soft_radius_sq) ? STEP_RECIP : STEP_Q;
      STEP_RECIP: step_next = STEP_CONTRIB;
      STEP_SUM:   if (!fin) state_next = S_IDLE;
      STEP_OUT:   state_next = S_IDLE;
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign fpu_start = (state == S_ISSUE) && !((step == STEP_OUT) && out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_radius_sq <= FP_ONE;
      soft_radius_inv <= FP_ONE;
      grav_const <= FP_ONE;
    end else if (wr_en) begin
      case (wr_index)
        REG_SOFT_RADIUS_SQ:  soft_radius_sq <= wr_data;
        REG_SOFT_RADIUS_INV: soft_radius_inv <= wr_data;
        REG_GRAV_CONST:      grav_const <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= STEP_DX;
      sum <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tx <= target_x;
            ty <= target_y;
            tz <= target_z;
            sx <= source_x;
            sy <= source_y;
            sz <= source_z;
            mass <= source_mass;
            fin <= final_source;
            step <= STEP_DX;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (fpu_start) state <= S_WAIT;
        end
        S_WAIT: begin
          if (fpu_done) begin
            state <= state_next;
            step <= step_next;
            case (step)
              STEP_DX, STEP_SX, STEP_Q2: dx <= fpu_res;
              STEP_DY, STEP_SY:          dy <= fpu_res;
              STEP_DZ, STEP_SZ:          dz <= fpu_res;
              STEP_R2A:                  r2 <= fpu_res;
              STEP_R2B: r2 <= f_gt(fpu_res, FP_TINY_R2) ? fpu_res : FP_TINY_R2;
              STEP_SQRT:                 rr <= fpu_res;
              STEP_Q, STEP_P0, STEP_P1, STEP_P2, STEP_P3: pp <= fpu_res;
              STEP_RECIP, STEP_FAC, STEP_CONTRIB: fac <= fpu_res;
              STEP_SUM:                  sum <= fpu_res;
              STEP_OUT: begin
                potential <= fpu_res;
                out_valid <= 1'b1;
                sum <= 32'd0;
              end
              default: ;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_softened_potential_accumulator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_softened_potential_accumulator_core
// Self-checking bench for the softened potential accumulator. Sources are sent
// in groups that end on a final mark; a single-precision predictor (rounded to
// nearest even from double-precision intermediates) accumulates the potential
// and queues each scaled result, which is compared with the block's output.
// Covers directed corner values, register extremes and random groups under
// several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_softened_potential_accumulator_core import spa_pkg::*; ();

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS_PER_PHASE = 500;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] target_x, target_y, target_z;
  logic [31:0] source_x, source_y, source_z, source_mass;
  logic        final_source;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] potential;

  logic [31:0] cfg_radius_sq, cfg_radius_inv, cfg_grav;
  logic [31:0] running_potential;
  logic [31:0] potential_q[$];
  int          err_cnt, sources_sent, potentials_seen, idle_cycles;
  int          send_idle_pct, recv_stall_pct;

  softened_potential_accumulator_core u_top (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .source_x(source_x), .source_y(source_y), .source_z(source_z),
    .source_mass(source_mass), .final_source(final_source),
    .out_valid(out_valid), .out_ready(out_ready), .potential(potential)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // single-precision helpers
  function automatic real to_real(logic [31:0] b);
    logic [23:0] mant;
    logic [63:0] d;
    int          e;
    mant = {b[30:23] != 0, b[22:0]};
    e = int'(b[30:23]);
    if (e == 255) begin
      d = (b[22:0] == 0) ? {b[31], 11'h7FF, 52'h0} : 64'h7FF8000000000000;
    end else if (b[30:0] == 0) begin
      d = {b[31], 63'h0};
    end else begin
      if (e == 0) begin
        e = 1;
        while (!mant[23]) begin
          mant = mant << 1;
          e--;
        end
      end
      d = {b[31], 11'(e - 127 + 1023), mant[22:0], 29'h0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] to_single(real x);
    logic [63:0] d, mant, kept, rem, half;
    int          e, sh;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? FP_QNAN : {d[63], 8'hFF, 23'h0};
    if (d[62:52] == 0) return {d[63], 31'h0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], 8'hFF, 23'h0};
    mant = {11'h0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) return {d[63], 31'h0};
    kept = mant >> sh;
    rem = mant & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    if (e >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        e++;
      end
      if (e > 127) return {d[63], 8'hFF, 23'h0};
      return {d[63], 8'(e + 127), kept[22:0]};
    end
    return {d[63], kept[30:0]};
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) + to_real(b));
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) - to_real(b));
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) * to_real(b));
  endfunction

  function automatic bit is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  // one source into the running sum; a final source queues the scaled potential
  task automatic accumulate_source(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                   logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                   logic [31:0] mass, logic fin);
    logic [31:0] dx, dy, dz, r2, r, q, q2, p, factor;
    dx = f_sub(tx, sx);
    dy = f_sub(ty, sy);
    dz = f_sub(tz, sz);
    r2 = f_add(f_add(f_mul(dx, dx), f_mul(dy, dy)), f_mul(dz, dz));
    if (!(to_real(r2) > to_real(FP_TINY_R2))) r2 = FP_TINY_R2;
    r = to_single($sqrt(to_real(r2)));
    if (to_real(r2) > to_real(cfg_radius_sq)) begin
      factor = to_single(1.0 / to_real(r));
    end else begin
      q = f_mul(r, cfg_radius_inv);
      q2 = f_mul(q, q);
      p = f_add(f_mul(FP_KC2, q2), FP_KC1);
      p = f_add(f_mul(p, q2), FP_KC0);
      factor = f_mul(p, cfg_radius_inv);
    end
    running_potential = f_sub(running_potential, f_mul(mass, factor));
    if (fin) begin
      potential_q.insert(potential_q.size(), f_mul(running_potential, cfg_grav));
      running_potential = 32'h0;
    end
  endtask

  task automatic send_source(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] mass, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    target_x <= tx;
    target_y <= ty;
    target_z <= tz;
    source_x <= sx;
    source_y <= sy;
    source_z <= sz;
    source_mass <= mass;
    final_source <= fin;
    do @(posedge clk); while (!in_ready);
    accumulate_source(tx, ty, tz, sx, sy, sz, mass, fin);
    sources_sent++;
  endtask

  // hold input low until every queued potential is out and the core is idle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (potential_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_SOFT_RADIUS_SQ:  cfg_radius_sq = val;
      REG_SOFT_RADIUS_INV: cfg_radius_inv = val;
      REG_GRAV_CONST:      cfg_grav = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] h2, logic [31:0] hinv, logic [31:0] g);
    drain();
    write_reg(REG_SOFT_RADIUS_SQ, h2);
    write_reg(REG_SOFT_RADIUS_INV, hinv);
    write_reg(REG_GRAV_CONST, g);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] specials[10];
    specials = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00800000};
    case ($urandom_range(9))
      7:       return $urandom();
      8:       return specials[$urandom_range(9)];
      9:       return {1'($urandom), 8'($urandom_range(255)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(134, 118)), 23'($urandom)};
    endcase
  endfunction

  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // coincident source, distance floored
    send_source(FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE, 1'b1);
    // far source then near source in one group
    send_source(32'h0, 32'h0, 32'h0, 32'h40400000, 32'h0, 32'h0, 32'h40000000, 1'b0);
    send_source(32'h0, 32'h0, 32'h0, 32'h3F000000, 32'h3E800000, 32'h0, FP_ONE, 1'b1);
    // NaN coordinate
    send_source(32'h7FC00000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, FP_ONE, 1'b1);
    // infinite distance
    send_source(32'h7F800000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, FP_ONE, 1'b1);
    // overflowing square, infinite mass, negative zero mass
    send_source(32'h7F7FFFFF, 32'h0, 32'h0, 32'hFF7FFFFF, 32'h0, 32'h0, 32'h7F7FFFFF, 1'b0);
    send_source(32'h0, 32'h0, 32'h0, 32'h3F000000, 32'h0, 32'h0, 32'h7F800000, 1'b0);
    send_source(32'h0, 32'h0, 32'h0, 32'h3F000000, 32'h0, 32'h0, 32'h80000000, 1'b1);
    // subnormal offsets and mass, all-ones fields
    send_source(32'h00000001, 32'h807FFFFF, 32'h0, 32'h0, 32'h0, 32'h00000003,
                32'h00000001, 1'b1);
    send_source(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    // unmarked sources keep accumulating
    repeat (3) send_source(32'h0, 32'h0, 32'h0, 32'h3F400000, 32'h3F000000, 32'h0,
                           32'h3F800000, 1'b0);
    send_source(32'h0, 32'h0, 32'h0, 32'hBF400000, 32'h0, 32'h0, FP_ONE, 1'b1);
  endtask

  task automatic test_register_extremes;
    logic [31:0] h2_set[5], hinv_set[5], g_set[5];
    h2_set   = '{32'h0, 32'h7F800000, 32'h7FC00000, 32'h40800000, 32'hFFFFFFFF};
    hinv_set = '{32'h0, 32'h7F7FFFFF, 32'h00000001, 32'h3F000000, 32'hFFFFFFFF};
    g_set    = '{32'h0, 32'hFF7FFFFF, 32'h80000000, 32'h3DCCCCCD, 32'hFFFFFFFF};
    for (int k = 0; k < 5; k++) begin
      set_regs(h2_set[k], hinv_set[k], g_set[k]);
      write_reg(REG_UNUSED, $urandom());
      send_source(32'h0, 32'h0, 32'h0, 32'h3F000000, 32'h0, 32'h0, FP_ONE, 1'b0);
      send_source(32'h0, 32'h0, 32'h0, 32'h40A00000, 32'h0, 32'h0, FP_ONE, 1'b1);
    end
    set_regs(FP_ONE, FP_ONE, FP_ONE);
  endtask

  task automatic test_random_groups;
    int          sent;
    logic [31:0] tx, ty, tz;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph == 0) set_regs(32'h40800000, 32'h3F000000, 32'h3DCCCCCD);
      else if (ph == 3) set_regs(FP_ONE, FP_ONE, FP_ONE);
      else set_regs(rand_float(), rand_float(), rand_float());
      sent = 0;
      while (sent < RANDOM_ITEMS_PER_PHASE) begin
        tx = rand_float();
        ty = rand_float();
        tz = rand_float();
        for (int n = $urandom_range(6, 1); n > 0; n--) begin
          send_source(tx, ty, tz, rand_float(), rand_float(), rand_float(), rand_float(),
                      n == 1 && $urandom_range(19) != 0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      potentials_seen++;
      if (potential_q.size() == 0) begin
        $display("%0t: unexpected potential, expected none, actual %h", $time, potential);
        err_cnt++;
      end else begin
        if (is_nan(potential_q[0]) ? !is_nan(potential) : potential !== potential_q[0]) begin
          $display("%0t: potential mismatch, expected %h, actual %h",
                   $time, potential_q[0], potential);
          err_cnt++;
        end
        void'(potential_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_SOFT_RADIUS_SQ;
    wr_data = 32'h0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {target_x, target_y, target_z} = '0;
    {source_x, source_y, source_z, source_mass} = '0;
    final_source = 1'b0;
    cfg_radius_sq = FP_ONE;
    cfg_radius_inv = FP_ONE;
    cfg_grav = FP_ONE;
    running_potential = 32'h0;
    err_cnt = 0;
    sources_sent = 0;
    potentials_seen = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_groups();
    drain();
    $display("Sent %0d sources and checked %0d potentials across corner values,",
             sources_sent, potentials_seen);
    $display("register extremes and four stall mixes.");
    if (err_cnt == 0 && potential_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
